// ===== rtl/core/rks_pkg.sv =====
// shared widths, opcodes and the memory request bundle for the range k-th smallest unit
// no dependencies
package rks_pkg;

  localparam int VAL_W        = 31;
  localparam int IDX_W        = 10;
  localparam int CNT_W        = 11;
  localparam int RANK_W       = 11;
  localparam int MAX_ELEMENTS = 1024;
  localparam int BLOCK_SIZE   = 32;
  localparam int OFF_W        = 5;
  localparam int BLK_W        = IDX_W - OFF_W;
  localparam int FILL_W       = OFF_W + 1;
  localparam int SH_W         = 5;
  localparam int TOP_BIT      = 30;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CHANGE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic e_we;
    idx_t e_waddr;
    val_t e_wdata;
    idx_t e_raddr;
    logic s_we;
    idx_t s_waddr;
    val_t s_wdata;
    idx_t s_raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/rks_mem.sv =====
// element store and per-block sorted copies, one write and one registered read each
// depends on rks_pkg
module rks_mem (
  input  logic             clk,
  input  rks_pkg::mem_req_t req,
  output rks_pkg::val_t    e_rdata,
  output rks_pkg::val_t    s_rdata
);
  import rks_pkg::*;

  val_t elem_mem   [MAX_ELEMENTS];
  val_t sorted_mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (req.e_we) begin
      elem_mem[req.e_waddr] <= req.e_wdata;
    end
    e_rdata <= elem_mem[req.e_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.s_we) begin
      sorted_mem[req.s_waddr] <= req.s_wdata;
    end
    s_rdata <= sorted_mem[req.s_raddr];
  end

endmodule

// ===== rtl/core/range_kth_smallest_with_updates_unit.sv =====
// load and change both finish with an insertion walk through one block's sorted copy
// query: 31 search rounds; a round reads each edge element in turn, binary searches
// every full block between them, and skips the scan for an empty range
// one transaction at a time through one shared comparator; busy is high while working
// the result strobe done lasts one cycle and the receiver cannot stall it
// sync reset clears the sequencer and the element count; stored values stay undefined
module range_kth_smallest_with_updates_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op,
  input  rks_pkg::idx_t              position,
  input  rks_pkg::idx_t              left,
  input  rks_pkg::idx_t              right,
  input  logic [rks_pkg::RANK_W-1:0] rank,
  input  rks_pkg::val_t              value,
  output logic                       done,
  output rks_pkg::val_t              kth_value
);
  import rks_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_LRD   = 16'h0002,
    S_LCMP  = 16'h0004,
    S_COLD  = 16'h0008,
    S_CSRD  = 16'h0010,
    S_CSCMP = 16'h0020,
    S_CDRD  = 16'h0040,
    S_CDCMP = 16'h0080,
    S_CURD  = 16'h0100,
    S_CUCMP = 16'h0200,
    S_QRND  = 16'h0400,
    S_QERD  = 16'h0800,
    S_QECMP = 16'h1000,
    S_QBRD  = 16'h2000,
    S_QBCMP = 16'h4000,
    S_QNEXT = 16'h8000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic done_next;
  val_t kth, kth_next;
  val_t val_r, val_next, old_r, old_next, c_r, c_next, cand, cand_next;
  logic [SH_W-1:0] sh, sh_next;
  logic [CNT_W-1:0] n, n_next;
  idx_t i, i_next, iend, iend_next, lft, lft_next, rgt, rgt_next, pos, pos_next;
  logic phase, phase_next, empty, empty_next;
  logic [BLK_W-1:0] ba, ba_next, bb, bb_next, blk, blk_next, base, base_next;
  logic [FILL_W-1:0] lo, lo_next, hi, hi_next, mid, mid_next, j, j_next, fill, fill_next;
  logic [RANK_W-1:0] rank_r, rank_next;

  mem_req_t req;
  val_t e_rdata, s_rdata;
  val_t cmp_a, cmp_b;
  logic lt;
  logic [FILL_W-1:0] mid_c, jm1, jp1;
  logic [CNT_W-1:0] rem, cnt_m1;
  idx_t rclamp;

  rks_mem u_mem (
    .clk     (clk),
    .req     (req),
    .e_rdata (e_rdata),
    .s_rdata (s_rdata)
  );

  // the one shared comparator
  always_comb begin
    cmp_a = s_rdata;
    cmp_b = c_r;
    if (state == S_LCMP || state == S_CDCMP) begin
      cmp_a = val_r;
      cmp_b = s_rdata;
    end else if (state == S_CSCMP) begin
      cmp_b = old_r;
    end else if (state == S_CUCMP) begin
      cmp_b = val_r;
    end else if (state == S_QECMP) begin
      cmp_a = e_rdata;
    end
    lt = cmp_a < cmp_b;
  end

  assign mid_c  = FILL_W'((({1'b0, lo}) + ({1'b0, hi})) >> 1);
  assign jm1    = j - FILL_W'(1);
  assign jp1    = j + FILL_W'(1);
  assign cnt_m1 = count - CNT_W'(1);
  assign rclamp = ({1'b0, right} >= count) ? cnt_m1[IDX_W-1:0] : right;
  assign rem    = count - {1'b0, position[IDX_W-1:OFF_W], {OFF_W{1'b0}}};
  assign busy   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    done_next  = 1'b0;
    kth_next   = kth;
    val_next   = val_r;
    old_next   = old_r;
    c_next     = c_r;
    cand_next  = cand;
    sh_next    = sh;
    n_next     = n;
    i_next     = i;
    iend_next  = iend;
    lft_next   = lft;
    rgt_next   = rgt;
    pos_next   = pos;
    phase_next = phase;
    empty_next = empty;
    ba_next    = ba;
    bb_next    = bb;
    blk_next   = blk;
    base_next  = base;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    j_next     = j;
    fill_next  = fill;
    rank_next  = rank_r;
    req         = '0;
    req.e_raddr = (state == S_IDLE) ? position : i;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op_t'(op))
            OP_LOAD: begin
              if (count != CNT_W'(MAX_ELEMENTS)) begin
                req.e_we    = 1'b1;
                req.e_waddr = count[IDX_W-1:0];
                req.e_wdata = value;
                base_next   = count[IDX_W-1:OFF_W];
                j_next      = {1'b0, count[OFF_W-1:0]};
                val_next    = value;
                count_next  = count + CNT_W'(1);
                state_next  = S_LRD;
              end
            end
            OP_CHANGE: begin
              if ({1'b0, position} < count) begin
                base_next  = position[IDX_W-1:OFF_W];
                pos_next   = position;
                val_next   = value;
                fill_next  = (rem >= CNT_W'(BLOCK_SIZE)) ? FILL_W'(BLOCK_SIZE)
                                                         : rem[FILL_W-1:0];
                state_next = S_COLD;
              end
            end
            OP_QUERY: begin
              lft_next   = left;
              rgt_next   = rclamp;
              ba_next    = left[IDX_W-1:OFF_W];
              bb_next    = rclamp[IDX_W-1:OFF_W];
              empty_next = (count == '0) || (left > rclamp);
              rank_next  = rank;
              cand_next  = '0;
              sh_next    = SH_W'(TOP_BIT);
              state_next = S_QRND;
            end
            default: begin
            end
          endcase
        end
      end

      // insertion walk of a load
      S_LRD: begin
        if (j == '0) begin
          req.s_we    = 1'b1;
          req.s_waddr = {base, {OFF_W{1'b0}}};
          req.s_wdata = val_r;
          state_next  = S_IDLE;
        end else begin
          req.s_raddr = {base, jm1[OFF_W-1:0]};
          state_next  = S_LCMP;
        end
      end
      S_LCMP: begin
        req.s_we    = 1'b1;
        req.s_waddr = {base, j[OFF_W-1:0]};
        if (lt) begin
          req.s_wdata = s_rdata;
          j_next      = jm1;
          state_next  = S_LRD;
        end else begin
          req.s_wdata = val_r;
          state_next  = S_IDLE;
        end
      end

      // change: fetch old value, locate it, then move the new one into place
      S_COLD: begin
        old_next    = e_rdata;
        req.e_we    = 1'b1;
        req.e_waddr = pos;
        req.e_wdata = val_r;
        lo_next     = '0;
        hi_next     = fill;
        state_next  = S_CSRD;
      end
      S_CSRD: begin
        if (lo < hi) begin
          mid_next    = mid_c;
          req.s_raddr = {base, mid_c[OFF_W-1:0]};
          state_next  = S_CSCMP;
        end else begin
          j_next     = lo;
          state_next = (lo < fill) ? S_CDRD : S_IDLE;
        end
      end
      S_CSCMP: begin
        if (lt) lo_next = mid + FILL_W'(1);
        else    hi_next = mid;
        state_next = S_CSRD;
      end
      S_CDRD: begin
        if (j == '0) begin
          state_next = S_CURD;
        end else begin
          req.s_raddr = {base, jm1[OFF_W-1:0]};
          state_next  = S_CDCMP;
        end
      end
      S_CDCMP: begin
        if (lt) begin
          req.s_we    = 1'b1;
          req.s_waddr = {base, j[OFF_W-1:0]};
          req.s_wdata = s_rdata;
          j_next      = jm1;
          state_next  = S_CDRD;
        end else begin
          state_next = S_CURD;
        end
      end
      S_CURD: begin
        if (jp1 < fill) begin
          req.s_raddr = {base, jp1[OFF_W-1:0]};
          state_next  = S_CUCMP;
        end else begin
          req.s_we    = 1'b1;
          req.s_waddr = {base, j[OFF_W-1:0]};
          req.s_wdata = val_r;
          state_next  = S_IDLE;
        end
      end
      S_CUCMP: begin
        req.s_we    = 1'b1;
        req.s_waddr = {base, j[OFF_W-1:0]};
        if (lt) begin
          req.s_wdata = s_rdata;
          j_next      = jp1;
          state_next  = S_CURD;
        end else begin
          req.s_wdata = val_r;
          state_next  = S_IDLE;
        end
      end

      // query: one round per result bit
      S_QRND: begin
        c_next = cand | (val_t'(1) << sh);
        n_next = '0;
        if (empty) begin
          state_next = S_QNEXT;
        end else begin
          i_next     = lft;
          iend_next  = (ba == bb) ? rgt : {ba, {OFF_W{1'b1}}};
          phase_next = 1'b0;
          state_next = S_QERD;
        end
      end
      S_QERD: begin
        state_next = S_QECMP;
      end
      S_QECMP: begin
        n_next = n + CNT_W'(lt);
        if (i == iend) begin
          if (!phase && ba != bb) begin
            phase_next = 1'b1;
            i_next     = {bb, {OFF_W{1'b0}}};
            iend_next  = rgt;
            state_next = S_QERD;
          end else if (ba != bb && BLK_W'(ba + BLK_W'(1)) != bb) begin
            blk_next   = ba + BLK_W'(1);
            lo_next    = '0;
            hi_next    = FILL_W'(BLOCK_SIZE);
            state_next = S_QBRD;
          end else begin
            state_next = S_QNEXT;
          end
        end else begin
          i_next     = i + IDX_W'(1);
          state_next = S_QERD;
        end
      end
      S_QBRD: begin
        if (lo < hi) begin
          mid_next    = mid_c;
          req.s_raddr = {blk, mid_c[OFF_W-1:0]};
          state_next  = S_QBCMP;
        end else begin
          n_next = n + CNT_W'(lo);
          if (BLK_W'(blk + BLK_W'(1)) == bb) begin
            state_next = S_QNEXT;
          end else begin
            blk_next = blk + BLK_W'(1);
            lo_next  = '0;
            hi_next  = FILL_W'(BLOCK_SIZE);
          end
        end
      end
      S_QBCMP: begin
        if (lt) lo_next = mid + FILL_W'(1);
        else    hi_next = mid;
        state_next = S_QBRD;
      end
      S_QNEXT: begin
        if (n < rank_r) cand_next = c_r;
        if (sh == '0) begin
          done_next  = 1'b1;
          kth_next   = (n < rank_r) ? c_r : cand;
          state_next = S_IDLE;
        end else begin
          sh_next    = sh - SH_W'(1);
          state_next = S_QRND;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    kth    <= kth_next;
    val_r  <= val_next;
    old_r  <= old_next;
    c_r    <= c_next;
    cand   <= cand_next;
    sh     <= sh_next;
    n      <= n_next;
    i      <= i_next;
    iend   <= iend_next;
    lft    <= lft_next;
    rgt    <= rgt_next;
    pos    <= pos_next;
    phase  <= phase_next;
    empty  <= empty_next;
    ba     <= ba_next;
    bb     <= bb_next;
    blk    <= blk_next;
    base   <= base_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    j      <= j_next;
    fill   <= fill_next;
    rank_r <= rank_next;
  end

  assign kth_value = kth;

  a_done_after_round: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_QNEXT)
    else $error("result strobe without a finished search");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count past capacity");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_CSRD || state == S_QBRD) |-> lo <= hi)
    else $error("binary search window inverted");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_QUERY) |=> busy)
    else $error("query transaction not taken up");

endmodule

// ===== tb/kth_monitor.sv =====
// watches the command and result ports of the range k-th smallest unit, predicts each answer
// and compares it with the unit's result; depends on rks_pkg
module kth_monitor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 op,
  input  rks_pkg::idx_t              position,
  input  rks_pkg::idx_t              left,
  input  rks_pkg::idx_t              right,
  input  logic [rks_pkg::RANK_W-1:0] rank,
  input  rks_pkg::val_t              value,
  input  logic                       done,
  input  rks_pkg::val_t              kth_value,
  output int                         errors,
  output int                         outstanding
);
  import rks_pkg::*;

  val_t elems [MAX_ELEMENTS];
  int   elem_count;
  val_t kth_expected [$];

  // bitwise search: keep a candidate while fewer than k range values lie below it
  function automatic val_t kth_of_range(idx_t lo, idx_t hi, logic [RANK_W-1:0] k);
    logic [31:0] cand;
    logic [31:0] c;
    logic [31:0] step;
    int          n;
    int          top;
    bit          empty;
    empty = (elem_count == 0);
    top = hi;
    if (!empty && top >= elem_count) top = elem_count - 1;
    if (int'(lo) > top) empty = 1;
    cand = 0;
    for (step = 32'h4000_0000; step != 0; step = step >> 1) begin
      c = cand + step;
      n = 0;
      if (!empty)
        for (int i = lo; i <= top; i++)
          if ({1'b0, elems[i]} < c) n++;
      if (n < k) cand = c;
    end
    return cand[VAL_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      elem_count = 0;
      kth_expected.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (kth_expected.size() == 0) begin
          $error("kth_value: unexpected result %0d", kth_value);
          errors++;
        end else begin
          val_t exp_val;
          exp_val = kth_expected.pop_front();
          if (kth_value !== exp_val) begin
            $error("kth_value: expected %0d, actual %0d", exp_val, kth_value);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        case (op_t'(op))
          OP_LOAD: begin
            if (elem_count < MAX_ELEMENTS) begin
              elems[elem_count] = value;
              elem_count++;
            end
          end
          OP_CHANGE: if (int'(position) < elem_count) elems[position] = value;
          OP_QUERY:  kth_expected = {kth_expected, kth_of_range(left, right, rank)};
          default: ;
        endcase
      end
    end
    outstanding = kth_expected.size();
  end
endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the range k-th smallest unit: directed cases, random bursts, then wide ranges
// depends on rks_pkg, range_kth_smallest_with_updates_unit and kth_monitor
module testbench;
  import rks_pkg::*;

  localparam int IDLE_LIMIT = 100000;

  logic              clk = 0;
  logic              rst = 1;
  logic              start = 0;
  logic              busy;
  logic [1:0]        op = OP_NONE;
  idx_t              position = '0;
  idx_t              left = '0;
  idx_t              right = '0;
  logic [RANK_W-1:0] rank = '0;
  val_t              value = '0;
  logic              done;
  val_t              kth_value;
  int                errors;
  int                outstanding;
  int                loaded;
  int                idle_cycles;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  range_kth_smallest_with_updates_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .position(position),
    .left(left), .right(right), .rank(rank), .value(value), .done(done),
    .kth_value(kth_value)
  );

  kth_monitor mon (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .position(position),
    .left(left), .right(right), .rank(rank), .value(value), .done(done),
    .kth_value(kth_value), .errors(errors), .outstanding(outstanding)
  );

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(op_t o, int p, int l, int r, int k, logic [31:0] v);
    op <= o;
    position <= idx_t'(p);
    left <= idx_t'(l);
    right <= idx_t'(r);
    rank <= RANK_W'(k);
    value <= v[VAL_W-1:0];
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (o == OP_LOAD && loaded < MAX_ELEMENTS) loaded++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'h7FFF_FFF8 + $urandom_range(0, 7);
      default: return $urandom() & 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic random_item();
    int sel;
    int l;
    int len;
    sel = $urandom_range(0, 99);
    if (sel < 30 && loaded < 160) send(OP_LOAD, $urandom(), $urandom(), $urandom(), $urandom(),
                                       rand_value());
    else if (sel < 60) begin
      if ($urandom_range(0, 9) == 0 || loaded == 0)
        send(OP_CHANGE, $urandom_range(0, 1023), $urandom(), $urandom(), $urandom(),
             rand_value());
      else
        send(OP_CHANGE, $urandom_range(0, loaded - 1), $urandom(), $urandom(), $urandom(),
             rand_value());
    end else if (sel < 95) begin
      if ($urandom_range(0, 7) == 0)
        send(OP_QUERY, $urandom(), $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 2047), 0);
      else begin
        // mostly short ranges so queries stay cheap
        l = (loaded > 0) ? $urandom_range(0, loaded - 1) : 0;
        len = $urandom_range(0, 40);
        send(OP_QUERY, $urandom(), l, l + len > 1023 ? 1023 : l + len,
             $urandom_range(0, 3) == 0 ? $urandom_range(0, 45) : $urandom_range(1, len + 1),
             $urandom());
      end
    end else send(OP_NONE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  initial begin
    int burst;
    loaded = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty array, unused op, change with nothing loaded
    send(OP_QUERY, 0, 0, 1023, 0, 0);
    send(OP_QUERY, 0, 0, 0, 1, 0);
    send(OP_NONE, 1023, 1023, 1023, 2047, 32'h7FFF_FFFF);
    send(OP_CHANGE, 0, 0, 0, 0, 5);
    // extremes of value, duplicates
    send(OP_LOAD, 0, 0, 0, 0, 32'h7FFF_FFFF);
    send(OP_LOAD, 0, 0, 0, 0, 0);
    send(OP_LOAD, 0, 0, 0, 0, 7);
    send(OP_LOAD, 0, 0, 0, 0, 7);
    for (int i = 0; i < 36; i++) send(OP_LOAD, 0, 0, 0, 0, rand_value());
    send(OP_QUERY, 0, 0, 3, 1, 0);
    send(OP_QUERY, 0, 0, 3, 4, 0);
    send(OP_QUERY, 0, 0, 3, 5, 0);
    send(OP_QUERY, 0, 0, 3, 0, 0);
    send(OP_QUERY, 0, 3, 1, 1, 0);
    send(OP_QUERY, 0, 2, 1023, 20, 0);
    send(OP_QUERY, 0, 5, 39, 2047, 0);
    send(OP_CHANGE, 1, 0, 0, 0, 32'h7FFF_FFFF);
    send(OP_CHANGE, 0, 0, 0, 0, 0);
    send(OP_CHANGE, 500, 0, 0, 0, 3);
    send(OP_QUERY, 0, 0, 39, 1, 0);
    send(OP_QUERY, 0, 0, 39, 40, 0);
    drain();

    for (int i = 0; i < 50; i++) begin
      burst = $urandom_range(1, 8);
      for (int j = 0; j < burst; j++) random_item();
      if (i == 25) drain();
      if ($urandom_range(0, 4) != 0) pause($urandom_range(1, 12));
    end

    // wide ranges over everything loaded so far
    send(OP_QUERY, 0, 0, 1023, 1024, 0);
    send(OP_QUERY, 0, 0, 1023, loaded / 2, 0);
    send(OP_QUERY, 0, 1, 1023, 1, 0);
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
